// ===== design/fprm_pkg.sv =====
// shared constants and control structs for the frame period rate meter
// no dependencies
package fprm_pkg;

    localparam int WIN      = 256;                 // periods held in the window
    localparam int STAMP_W  = 48;                  // timestamp counter width
    localparam int TICKS_W  = 32;                  // period and register width
    localparam int RATE_W   = 24;                  // frame rate field width
    localparam int IDX_W    = $clog2(WIN);         // ring address width
    localparam int CNT_W    = $clog2(WIN + 1);     // fill count width
    localparam int SUM_W    = TICKS_W + IDX_W;     // window sum width
    localparam int PROD_W   = TICKS_W + CNT_W;     // count * tick_rate
    localparam int FRAC_W   = 8;                   // 1/256 fps scaling
    localparam int NUM_W    = PROD_W + FRAC_W;     // dividend width
    localparam int REM_W    = SUM_W + 1;           // partial remainder width
    localparam int DCNT_W   = $clog2(NUM_W);       // divider step counter width
    localparam int APB_AW   = 3;                   // two registers at 4*i
    localparam int APB_DW   = 32;

    localparam logic [TICKS_W-1:0] TICK_RATE_RST = 32'd10000000;
    localparam logic [TICKS_W-1:0] MAX_TICKS_RST = 32'd1000000;

    localparam logic [0:0] REG_TICK_RATE = 1'b0;
    localparam logic [0:0] REG_MAX_TICKS = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic rd_old;
        logic update;
        logic mul;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic div_skip;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

// ===== design/fprm_in_if.sv =====
// input channel carrying one frame timestamp word
// depends on fprm_pkg
interface fprm_in_if;
    logic                          valid;
    logic                          ready;
    logic [fprm_pkg::STAMP_W-1:0]  timestamp;

    modport source (output valid, output timestamp, input ready);
    modport sink   (input valid, input timestamp, output ready);
endinterface

// ===== design/fprm_out_if.sv =====
// output channel carrying one period and rate result word
// depends on fprm_pkg
interface fprm_out_if;
    logic                          valid;
    logic                          ready;
    logic [fprm_pkg::TICKS_W-1:0]  frame_ticks;
    logic [fprm_pkg::RATE_W-1:0]   frame_rate;
    logic [fprm_pkg::CNT_W-1:0]    window_fill;

    modport source (output valid, output frame_ticks, output frame_rate,
                    output window_fill, input ready);
    modport sink   (input valid, input frame_ticks, input frame_rate,
                    input window_fill, output ready);
endinterface

// ===== design/frame_period_rate_meter.sv =====
// frame period rate meter: one result word per timestamp word; the sequencer
// takes one word at a time, through read, update, multiply and the 49-step
// bit-serial rate divider, which is skipped on the first mark or a zero sum
// the output register lets the next word be taken while a result waits
// reset (i_rst_n, synchronous, active low) clears the sequencer, first-mark
// flag, window count, head, sum and registers; the ring ram is not cleared
module frame_period_rate_meter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fprm_in_if.sink                       i_frame,
    fprm_out_if.source                    o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fprm_pkg::APB_AW-1:0]   paddr,
    input  logic [fprm_pkg::APB_DW-1:0]   pwdata,
    output logic [fprm_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    // configuration registers
    logic [fprm_pkg::TICKS_W-1:0] r_tick_rate;
    logic [fprm_pkg::TICKS_W-1:0] r_max_ticks;

    // controller to datapath handshake
    fprm_pkg::t_cmd  cmd;
    fprm_pkg::t_stat stat;

    // register index is the word address; byte offset bits are ignored
    logic [0:0] reg_idx;
    logic       cfg_wr;

    assign reg_idx = paddr[2:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate <= fprm_pkg::TICK_RATE_RST;
            r_max_ticks <= fprm_pkg::MAX_TICKS_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                fprm_pkg::REG_TICK_RATE: r_tick_rate <= pwdata;
                fprm_pkg::REG_MAX_TICKS: r_max_ticks <= pwdata;
                default: ;
            endcase
        end
    end

    // read back the addressed register
    always_comb begin
        case (reg_idx)
            fprm_pkg::REG_TICK_RATE: prdata = r_tick_rate;
            fprm_pkg::REG_MAX_TICKS: prdata = r_max_ticks;
            default:                 prdata = '0;
        endcase
    end

    // sequencer: one word at a time through read, update, multiply, divide
    fprm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_frame.valid),
        .o_in_ready (i_frame.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: clamp, window ring and sum, rate arithmetic, output register
    fprm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_tick_rate   (r_tick_rate),
        .i_max_ticks   (r_max_ticks),
        .i_timestamp   (i_frame.timestamp),
        .i_out_ready   (o_result.ready),
        .o_out_valid   (o_result.valid),
        .o_frame_ticks (o_result.frame_ticks),
        .o_frame_rate  (o_result.frame_rate),
        .o_window_fill (o_result.window_fill)
    );

endmodule

// ===== design/fprm_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module fprm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/fprm_ctrl.sv =====
// sequencer for one frame mark: ring update, multiply, serial divide, result
// depends on fprm_pkg
module fprm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  fprm_pkg::t_stat i_stat,
    output fprm_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_MUL,
        S_DINIT,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_old = 1'b1;
                n_state      = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = i_stat.div_skip ? S_DONE : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.load_out = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== design/fprm_dp.sv =====
// datapath: period clamp, window ring and sum, rate multiply and serial divider
// depends on fprm_pkg and fprm_ram
module fprm_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fprm_pkg::t_cmd                 i_cmd,
    output fprm_pkg::t_stat                o_stat,
    input  logic [fprm_pkg::TICKS_W-1:0]   i_tick_rate,
    input  logic [fprm_pkg::TICKS_W-1:0]   i_max_ticks,
    input  logic [fprm_pkg::STAMP_W-1:0]   i_timestamp,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [fprm_pkg::TICKS_W-1:0]   o_frame_ticks,
    output logic [fprm_pkg::RATE_W-1:0]    o_frame_rate,
    output logic [fprm_pkg::CNT_W-1:0]     o_window_fill
);

    localparam logic [fprm_pkg::CNT_W-1:0]  CNT_FULL = fprm_pkg::CNT_W'(fprm_pkg::WIN);
    localparam logic [fprm_pkg::IDX_W-1:0]  IDX_LAST = fprm_pkg::IDX_W'(fprm_pkg::WIN - 1);
    localparam logic [fprm_pkg::DCNT_W-1:0] DCNT_LAST =
        fprm_pkg::DCNT_W'(fprm_pkg::NUM_W - 1);

    logic                           r_seen;
    logic [fprm_pkg::STAMP_W-1:0]   r_last;
    logic [fprm_pkg::TICKS_W-1:0]   r_ticks;
    logic                           r_push;
    logic [fprm_pkg::IDX_W-1:0]     r_head;
    logic [fprm_pkg::CNT_W-1:0]     r_count;
    logic [fprm_pkg::SUM_W-1:0]     r_sum;
    logic [fprm_pkg::PROD_W-1:0]    r_prod;
    logic [fprm_pkg::NUM_W-1:0]     r_num;
    logic [fprm_pkg::REM_W-1:0]     r_rem;
    logic [fprm_pkg::DCNT_W-1:0]    r_dcnt;
    logic                           r_out_valid;
    logic [fprm_pkg::TICKS_W-1:0]   r_out_ticks;
    logic [fprm_pkg::RATE_W-1:0]    r_out_rate;
    logic [fprm_pkg::CNT_W-1:0]     r_out_fill;

    logic [fprm_pkg::STAMP_W-1:0]   diff;
    logic [fprm_pkg::TICKS_W-1:0]   clamped;
    logic                           full;
    logic [fprm_pkg::CNT_W-1:0]     slot_sum;
    logic [fprm_pkg::IDX_W-1:0]     slot;
    logic [fprm_pkg::IDX_W-1:0]     head_inc;
    logic [fprm_pkg::TICKS_W-1:0]   old_period;
    logic                           ram_we;
    logic [fprm_pkg::IDX_W-1:0]     ram_waddr;
    logic                           ram_re;
    logic [fprm_pkg::REM_W-1:0]     rem_sh;
    logic [fprm_pkg::REM_W-1:0]     rem_sub;
    logic                           qbit;
    logic                           rate_sat;
    logic                           out_free;

    // elapsed ticks wrap at the counter width, then clamp
    assign diff    = i_timestamp - r_last;
    assign clamped = (diff > fprm_pkg::STAMP_W'(i_max_ticks)) ? i_max_ticks
                                                              : diff[fprm_pkg::TICKS_W-1:0];

    assign full     = (r_count == CNT_FULL);
    assign slot_sum = fprm_pkg::CNT_W'(r_head) + r_count;
    assign slot     = (slot_sum >= CNT_FULL) ? fprm_pkg::IDX_W'(slot_sum - CNT_FULL)
                                             : slot_sum[fprm_pkg::IDX_W-1:0];
    assign head_inc = (r_head == IDX_LAST) ? '0 : r_head + 1'b1;

    assign ram_re    = i_cmd.rd_old && r_push && full;
    assign ram_we    = i_cmd.update && r_push;
    assign ram_waddr = full ? r_head : slot;

    fprm_ram #(
        .WIDTH (fprm_pkg::TICKS_W),
        .DEPTH (fprm_pkg::WIN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_ticks),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (old_period)
    );

    // restoring divide, one quotient bit per step shifted into r_num
    assign rem_sh  = {r_rem[fprm_pkg::REM_W-2:0], r_num[fprm_pkg::NUM_W-1]};
    assign qbit    = (rem_sh >= fprm_pkg::REM_W'(r_sum));
    assign rem_sub = qbit ? rem_sh - fprm_pkg::REM_W'(r_sum) : rem_sh;

    assign rate_sat = |r_num[fprm_pkg::NUM_W-1:fprm_pkg::RATE_W];
    assign out_free = !r_out_valid || i_out_ready;

    assign o_stat.div_skip = (r_count == '0) || (r_sum == '0);
    assign o_stat.div_last = (r_dcnt == DCNT_LAST);
    assign o_stat.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_last      <= '0;
            r_push      <= 1'b0;
            r_head      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_seen  <= 1'b1;
                r_last  <= i_timestamp;
                r_push  <= r_seen;
                r_ticks <= r_seen ? clamped : '0;
            end
            if (i_cmd.update && r_push) begin
                if (full) begin
                    r_sum  <= r_sum - fprm_pkg::SUM_W'(old_period)
                                    + fprm_pkg::SUM_W'(r_ticks);
                    r_head <= head_inc;
                end else begin
                    r_sum   <= r_sum + fprm_pkg::SUM_W'(r_ticks);
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.mul) begin
                r_prod <= fprm_pkg::PROD_W'(r_count) * fprm_pkg::PROD_W'(i_tick_rate);
            end
            if (i_cmd.div_init) begin
                r_rem  <= '0;
                r_dcnt <= '0;
                if (r_count == '0) begin
                    r_num <= '0;
                end else if (r_sum == '0) begin
                    r_num <= '1;
                end else begin
                    r_num <= {r_prod, {fprm_pkg::FRAC_W{1'b0}}};
                end
            end
            if (i_cmd.div_step) begin
                r_rem  <= rem_sub;
                r_num  <= {r_num[fprm_pkg::NUM_W-2:0], qbit};
                r_dcnt <= r_dcnt + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
                r_out_ticks <= r_ticks;
                r_out_rate  <= rate_sat ? '1 : r_num[fprm_pkg::RATE_W-1:0];
                r_out_fill  <= r_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_frame_ticks = r_out_ticks;
    assign o_frame_rate  = r_out_rate;
    assign o_window_fill = r_out_fill;

endmodule

// ===== test/frame_period_rate_meter_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench for frame_period_rate_meter: timestamp words in, period/rate words out
// depends on fprm_pkg, fprm_in_if, fprm_out_if and the frame_period_rate_meter rtl
module frame_period_rate_meter_test;

    localparam int LIMIT    = 1000000;   // cycle budget for the whole run
    localparam int HOLD_AT  = 400;       // input word count that starts the long result stall
    localparam int HOLD_LEN = 1000;      // length of that stall in cycles
    localparam int TAIL     = 100;       // quiet cycles after the last result
    localparam int N_RAND   = 280;       // words per random phase

    typedef struct packed {
        logic [fprm_pkg::TICKS_W-1:0] ticks;
        logic [fprm_pkg::RATE_W-1:0]  rate;
        logic [fprm_pkg::CNT_W-1:0]   fill;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [fprm_pkg::APB_AW-1:0] paddr;
    logic [fprm_pkg::APB_DW-1:0] pwdata, prdata;

    fprm_in_if  frame_if ();
    fprm_out_if result_if ();

    frame_period_rate_meter uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // register copies seen by the predictor
    logic [fprm_pkg::TICKS_W-1:0] cfg_tick = fprm_pkg::TICK_RATE_RST;
    logic [fprm_pkg::TICKS_W-1:0] cfg_max  = fprm_pkg::MAX_TICKS_RST;

    // predicted meter state
    logic                         m_seen = 1'b0;
    logic [fprm_pkg::STAMP_W-1:0] m_last = '0;
    logic [fprm_pkg::TICKS_W-1:0] m_ring [fprm_pkg::WIN];
    logic [fprm_pkg::IDX_W-1:0]   m_head = '0;
    logic [fprm_pkg::CNT_W-1:0]   m_count = '0;
    logic [fprm_pkg::SUM_W-1:0]   m_sum = '0;

    logic [fprm_pkg::STAMP_W-1:0] stamp_q [$];      // timestamp words waiting to be sent
    t_result                      due_results [$];  // predicted results not yet seen
    logic [fprm_pkg::STAMP_W-1:0] gen_last = '0;    // last stamp handed to the sender

    int send_idle_pct = 24;
    int recv_idle_pct = 49;
    int in_count = 0;
    int out_count = 0;
    int err_count = 0;
    int cycles = 0;
    int hold_left = 0;
    logic hold_used = 1'b0;
    t_result got, want;

    // one mark through the meter: period, window update, rate
    function automatic t_result advance_meter(input logic [fprm_pkg::STAMP_W-1:0] stamp);
        t_result r;
        logic [fprm_pkg::STAMP_W-1:0] diff;
        logic [fprm_pkg::TICKS_W-1:0] p;
        logic [fprm_pkg::IDX_W-1:0] slot;
        logic [63:0] num;
        logic [63:0] q;
        p = '0;
        if (m_seen) begin
            diff = stamp - m_last;
            p = (diff > fprm_pkg::STAMP_W'(cfg_max)) ? cfg_max
                                                     : diff[fprm_pkg::TICKS_W-1:0];
            if (m_count == fprm_pkg::CNT_W'(fprm_pkg::WIN)) begin
                // window full: drop the oldest period
                slot = m_head;
                m_sum = m_sum - fprm_pkg::SUM_W'(m_ring[slot]);
                m_head = m_head + 1'b1;
            end else begin
                slot = m_head + m_count[fprm_pkg::IDX_W-1:0];
                m_count = m_count + 1'b1;
            end
            m_ring[slot] = p;
            m_sum = m_sum + fprm_pkg::SUM_W'(p);
        end else begin
            m_seen = 1'b1;
        end
        m_last = stamp;
        r.ticks = p;
        r.fill = m_count;
        if (m_count == 0) begin
            r.rate = '0;
        end else if (m_sum == 0) begin
            r.rate = '1;
        end else begin
            num = (64'(m_count) * 64'(cfg_tick)) << fprm_pkg::FRAC_W;
            q = num / 64'(m_sum);
            r.rate = (q > 64'(24'hFFFFFF)) ? '1 : q[fprm_pkg::RATE_W-1:0];
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
        err_count++;
        $display("mismatch %s: expected %0d got %0d (result %0d)",
                 what, exp_v, got_v, out_count);
    endtask

    // register value for a phase: extremes or random
    function automatic logic [fprm_pkg::TICKS_W-1:0] pick_reg();
        int sel;
        sel = $urandom_range(99);
        if (sel < 20)
            return 32'd1;
        else if (sel < 40)
            return 32'hFFFFFFFF;
        else if (sel < 70)
            return $urandom_range(5000, 1);
        else
            return $urandom;
    endfunction

    // next stamp of the random stream, mostly well-formed periods
    function automatic logic [fprm_pkg::STAMP_W-1:0] next_stamp();
        logic [fprm_pkg::STAMP_W-1:0] s;
        logic [fprm_pkg::TICKS_W-1:0] lim;
        logic [63:0] w;
        int sel;
        sel = $urandom_range(99);
        lim = (cfg_max == 0) ? 32'd1000 : cfg_max;
        w = {$urandom, $urandom};
        if (sel < 12)
            s = gen_last + fprm_pkg::STAMP_W'($urandom_range(16, 1));
        else if (sel < 70)
            s = gen_last + fprm_pkg::STAMP_W'($urandom_range(lim, 1));
        else if (sel < 78)
            s = gen_last + fprm_pkg::STAMP_W'(lim)
                + fprm_pkg::STAMP_W'($urandom_range(4096, 1));
        else if (sel < 84)
            s = gen_last;
        else if (sel < 90)
            s = gen_last - fprm_pkg::STAMP_W'($urandom_range(lim, 1));
        else
            s = w[fprm_pkg::STAMP_W-1:0];
        gen_last = s;
        return s;
    endfunction

    task automatic send_stamp(input logic [fprm_pkg::STAMP_W-1:0] s);
        stamp_q = {stamp_q, s};
        gen_last = s;
    endtask

    // apb read of one register, compared with the expected value
    task automatic reg_check(input logic [0:0] idx,
                             input logic [fprm_pkg::TICKS_W-1:0] exp_v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata != exp_v)
            flag_mismatch("register readback", 64'(exp_v), 64'(prdata));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // apb write; only called while the meter is idle
    task automatic set_reg(input logic [0:0] idx, input logic [fprm_pkg::TICKS_W-1:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == fprm_pkg::REG_TICK_RATE)
            cfg_tick = v;
        else
            cfg_max = v;
        reg_check(idx, v);
    endtask

    task automatic set_both(input logic [fprm_pkg::TICKS_W-1:0] tick,
                            input logic [fprm_pkg::TICKS_W-1:0] mx);
        set_reg(fprm_pkg::REG_TICK_RATE, tick);
        set_reg(fprm_pkg::REG_MAX_TICKS, mx);
    endtask

    // sender holds off until every predicted result has come back
    task automatic drain();
        while (!(stamp_q.size() == 0 && !frame_if.valid && due_results.size() == 0))
            @(posedge i_clk);
    endtask

    task automatic random_phase(input int n);
        repeat (n) stamp_q = {stamp_q, next_stamp()};
        drain();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // word sender, fed from stamp_q
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_if.valid <= 1'b0;
        end else begin
            if (frame_if.valid && frame_if.ready) begin
                due_results = {due_results, advance_meter(frame_if.timestamp)};
                in_count <= in_count + 1;
            end
            if (!frame_if.valid || frame_if.ready) begin
                if (stamp_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    frame_if.valid <= 1'b1;
                    frame_if.timestamp <= stamp_q[0];
                    stamp_q.delete(0);
                end else begin
                    frame_if.valid <= 1'b0;
                end
            end
        end
    end

    // one long result stall, so the output register fills and input backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_used && in_count == HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_used <= 1'b1;
        end
    end

    // result receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                got.ticks = result_if.frame_ticks;
                got.rate = result_if.frame_rate;
                got.fill = result_if.window_fill;
                if (due_results.size() == 0) begin
                    flag_mismatch("result with nothing expected", 64'd0, 64'(got.ticks));
                end else begin
                    want = due_results[0];
                    due_results.delete(0);
                    if (got.ticks != want.ticks)
                        flag_mismatch("frame_ticks", 64'(want.ticks), 64'(got.ticks));
                    if (got.rate != want.rate)
                        flag_mismatch("frame_rate", 64'(want.rate), 64'(got.rate));
                    if (got.fill != want.fill)
                        flag_mismatch("window_fill", 64'(want.fill), 64'(got.fill));
                end
                out_count <= out_count + 1;
            end
            result_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        reg_check(fprm_pkg::REG_TICK_RATE, fprm_pkg::TICK_RATE_RST);
        reg_check(fprm_pkg::REG_MAX_TICKS, fprm_pkg::MAX_TICKS_RST);

        // directed marks under the reset settings
        send_stamp(48'h123456789ABC);              // first mark, empty window
        send_stamp(48'h123456789ABC);              // zero period, zero sum
        send_stamp(48'h123456789ABD);              // one tick, rate saturates
        send_stamp(gen_last + 48'd1000000);        // exactly the clamp
        send_stamp(gen_last + 48'd1000001);        // one over the clamp
        send_stamp(48'hFFFFFFFFFFFF);
        send_stamp(48'h000000000000);              // counter wrap
        send_stamp(48'h0000000F4240);
        send_stamp(48'h000000000010);              // going backwards
        send_stamp(48'hFFFFFFFFFFF0);
        send_stamp(48'h000000000005);
        drain();

        set_both(32'hFFFFFFFF, 32'hFFFFFFFF);
        send_stamp(gen_last + 48'd1);              // rate overflow
        send_stamp(gen_last + 48'h0000FFFFFFFF);   // widest period
        send_stamp(gen_last + 48'h000100000000);   // clamps to widest
        send_stamp(48'h555555555555);
        drain();

        set_both(32'd0, 32'd0);                    // zero tick rate, zero clamp
        send_stamp(gen_last + 48'd5);
        send_stamp(48'hAAAAAAAAAAAA);
        drain();

        set_both(32'd1, 32'd1);
        send_stamp(gen_last + 48'd2);
        send_stamp(gen_last + 48'd1);
        send_stamp(gen_last);
        drain();

        set_both(pick_reg(), pick_reg());
        random_phase(N_RAND);

        // swap the idle rates: sender idles more than receiver
        send_idle_pct = 49;
        recv_idle_pct = 24;
        set_both(pick_reg(), pick_reg());
        random_phase(N_RAND);
        set_both(pick_reg(), pick_reg());
        random_phase(N_RAND);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_both(32'hFFFFFFFF, pick_reg());
        random_phase(N_RAND);
        set_both(fprm_pkg::TICK_RATE_RST, fprm_pkg::MAX_TICKS_RST);
        random_phase(N_RAND);

        repeat (TAIL) @(posedge i_clk);
        if (due_results.size() != 0)
            flag_mismatch("results never delivered", 64'(due_results.size()), 64'd0);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
